// ----- sv/bts_pkg.sv -----
`timescale 1ns / 1ps
package bts_pkg;
	localparam int MAX_SIDE        = 256;
	localparam int COORD_FRAC_BITS = 16;
	localparam int CHANNEL_BITS    = 8;

	typedef enum logic [0:0] {
		REG_TEX_WIDTH  = 1'b0,
		REG_TEX_HEIGHT = 1'b1
	} reg_idx_t;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;
endpackage

// ----- sv/bts_bank.sv -----
`timescale 1ns / 1ps
module bts_bank #(
	parameter int AW = 14,
	parameter int DW = 24
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/bts_blend.sv -----
`timescale 1ns / 1ps
// One channel: weights times texels, summed, rounded and saturated. Two stages.
module bts_blend #(
	parameter int CB = 8,
	parameter int WB = 33
) (
	input  logic          clk,
	input  logic [CB-1:0] t00,
	input  logic [CB-1:0] t10,
	input  logic [CB-1:0] t01,
	input  logic [CB-1:0] t11,
	input  logic [WB-1:0] w00,
	input  logic [WB-1:0] w10,
	input  logic [WB-1:0] w01,
	input  logic [WB-1:0] w11,
	output logic [CB-1:0] res
);
	localparam int PB = WB + CB;
	localparam int SB = PB + 2;
	localparam int SH = WB - 1;
	logic [PB-1:0] p00_s1, p10_s1, p01_s1, p11_s1;
	logic [SB-1:0] sum;
	logic [SB-1:0] rnd;

	always_ff @(posedge clk) begin
		p00_s1 <= PB'(t00) * PB'(w00);
		p10_s1 <= PB'(t10) * PB'(w10);
		p01_s1 <= PB'(t01) * PB'(w01);
		p11_s1 <= PB'(t11) * PB'(w11);
	end

	always_comb begin
		sum = SB'(p00_s1) + SB'(p10_s1) + SB'(p01_s1) + SB'(p11_s1);
		rnd = (sum + (SB'(1) << (SH - 1))) >> SH;
	end

	always_ff @(posedge clk) begin
		res <= (rnd > SB'({CB{1'b1}})) ? {CB{1'b1}} : rnd[CB-1:0];
	end
endmodule

// ----- sv/bilinear_texture_sampler_unit.sv -----
`timescale 1ns / 1ps
// channel  signals                                         direction
// request  start/busy, opcode, u/v_coord, texel_x/y, rgb    in
// result   result_valid, red/green/blue_out                out
// config   cfg_valid/cfg_ready, cfg_index, cfg_data         in
// One request per cycle; busy stays low. A sample's result reaches the outputs
// after coordinate multiply, split and texel read, weight multiply, channel
// products and sum/round. Texels are kept in four copies, one per neighbour,
// so all four are read in one cycle. Writes hit the copies the cycle after
// acceptance. Reset sets both sizes to 2 and clears the valids; the texel
// memory is not cleared. Receiver cannot stall.
module bilinear_texture_sampler_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     opcode,
	input  logic [16:0]              u_coord,
	input  logic [16:0]              v_coord,
	input  logic [7:0]               texel_x,
	input  logic [7:0]               texel_y,
	input  logic [7:0]               red_in,
	input  logic [7:0]               green_in,
	input  logic [7:0]               blue_in,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic                     cfg_index,
	input  logic [8:0]               cfg_data,
	output logic                     result_valid,
	output logic [7:0]               red_out,
	output logic [7:0]               green_out,
	output logic [7:0]               blue_out
);
	localparam int MAX_SIDE        = bts_pkg::MAX_SIDE;
	localparam int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS;
	localparam int CHANNEL_BITS    = bts_pkg::CHANNEL_BITS;
	localparam int SB  = $clog2(MAX_SIDE);          // index bits
	localparam int SZB = SB + 1;                    // size bits
	localparam int FB  = COORD_FRAC_BITS;
	localparam int CB  = CHANNEL_BITS;
	localparam int DW  = 3 * CB;
	localparam int AW  = 2 * SB;
	localparam int PRB = FB + 1 + SZB;
	localparam int WB  = 2 * FB + 1;
	localparam int FRB = FB + 1;

	logic [SZB-1:0] width_q, height_q;
	logic [SZB-1:0] w_eff, h_eff;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SZB'(2);
			height_q <= SZB'(2);
		end else if (cfg_valid) begin
			unique case (bts_pkg::reg_idx_t'(cfg_index))
				bts_pkg::REG_TEX_WIDTH:  width_q  <= SZB'(cfg_data);
				bts_pkg::REG_TEX_HEIGHT: height_q <= SZB'(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		w_eff = (width_q == '0) ? SZB'(1) : width_q;
		h_eff = (height_q == '0) ? SZB'(1) : height_q;
		if (width_q > SZB'(MAX_SIDE)) w_eff = SZB'(MAX_SIDE);
		if (height_q > SZB'(MAX_SIDE)) h_eff = SZB'(MAX_SIDE);
	end

	// stage 1: saturate, flip, multiply
	logic          acc;
	logic [FB:0]   u_sat, v_sat, v_flip;
	logic          smp_s1, wr_s1;
	logic [PRB-1:0] pu_s1, pv_s1;
	logic [SZB-1:0] w_s1, h_s1;
	logic [7:0]    wx_s1, wy_s1;
	logic [DW-1:0] wd_s1;

	assign acc = start && !busy;

	always_comb begin
		u_sat = (17'(u_coord) > 17'(1 << FB)) ? (FB+1)'(1 << FB) : (FB+1)'(u_coord);
		v_sat = (17'(v_coord) > 17'(1 << FB)) ? (FB+1)'(1 << FB) : (FB+1)'(v_coord);
		v_flip = (FB+1)'(1 << FB) - v_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s1 <= 1'b0;
			wr_s1  <= 1'b0;
		end else begin
			smp_s1 <= acc && opcode == bts_pkg::OP_SAMPLE;
			wr_s1  <= acc && opcode == bts_pkg::OP_WRITE && 32'(texel_x) < MAX_SIDE
				&& 32'(texel_y) < MAX_SIDE;
		end
	end

	always_ff @(posedge clk) begin
		pu_s1 <= PRB'(u_sat) * PRB'(w_eff);
		pv_s1 <= PRB'(v_flip) * PRB'(h_eff);
		w_s1  <= w_eff;
		h_s1  <= h_eff;
		wx_s1 <= texel_x;
		wy_s1 <= texel_y;
		wd_s1 <= {DW'(blue_in[CB-1:0]) << (2*CB)} | {DW'(green_in[CB-1:0]) << CB}
			| DW'(red_in[CB-1:0]);
	end

	// stage 2: index, fraction, wrapped neighbours, texel read
	logic [SZB-1:0] ip, jp;
	logic [SB-1:0]  i0, j0, i1, j1;
	logic [FRB-1:0] fu, fv;
	logic [SB:0]    i_inc, j_inc;

	always_comb begin
		ip = SZB'(pu_s1 >> FB);
		jp = SZB'(pv_s1 >> FB);
		if (ip >= w_s1) ip = w_s1 - SZB'(1);
		if (jp >= h_s1) jp = h_s1 - SZB'(1);
		i0 = ip[SB-1:0];
		j0 = jp[SB-1:0];
		fu = FRB'(pu_s1 - (PRB'(ip) << FB));
		fv = FRB'(pv_s1 - (PRB'(jp) << FB));
		i_inc = (SB+1)'(ip) + (SB+1)'(1);
		j_inc = (SB+1)'(jp) + (SB+1)'(1);
		i1 = ((SZB)'(i_inc) >= w_s1) ? '0 : i_inc[SB-1:0];
		j1 = ((SZB)'(j_inc) >= h_s1) ? '0 : j_inc[SB-1:0];
	end

	// One copy per neighbour (00, 10, 01, 11); every write goes to all four.
	logic [AW-1:0] raddr [4];
	logic [DW-1:0] rdata [4];
	logic [AW-1:0] waddr;
	assign waddr = {wy_s1[SB-1:0], wx_s1[SB-1:0]};
	assign raddr[0] = {j0, i0};
	assign raddr[1] = {j0, i1};
	assign raddr[2] = {j1, i0};
	assign raddr[3] = {j1, i1};

	for (genvar b = 0; b < 4; b++) begin : g_bank
		bts_bank #(.AW(AW), .DW(DW)) u_bank (
			.clk(clk), .we(wr_s1), .waddr(waddr), .wdata(wd_s1),
			.raddr(raddr[b]), .rdata(rdata[b])
		);
	end

	logic           vld_s2;
	logic [FRB-1:0] fu_s2, fv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= smp_s1;
	end

	always_ff @(posedge clk) begin
		fu_s2 <= fu;
		fv_s2 <= fv;
	end

	// stage 3: texel capture, weights
	logic [FRB-1:0] gu, gv;
	always_comb begin
		gu = FRB'(1 << FB) - fu_s2;
		gv = FRB'(1 << FB) - fv_s2;
	end

	logic [DW-1:0] t00_s3, t10_s3, t01_s3, t11_s3;
	logic [WB-1:0] w00_s3, w10_s3, w01_s3, w11_s3;
	logic          vld_s3, vld_s4, vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		t00_s3 <= rdata[0];
		t10_s3 <= rdata[1];
		t01_s3 <= rdata[2];
		t11_s3 <= rdata[3];
		w00_s3 <= WB'(gu) * WB'(gv);
		w10_s3 <= WB'(fu_s2) * WB'(gv);
		w01_s3 <= WB'(gu) * WB'(fv_s2);
		w11_s3 <= WB'(fu_s2) * WB'(fv_s2);
	end

	logic [CB-1:0] ch [3];
	for (genvar c = 0; c < 3; c++) begin : g_ch
		bts_blend #(.CB(CB), .WB(WB)) u_blend (
			.clk(clk),
			.t00(t00_s3[c*CB +: CB]), .t10(t10_s3[c*CB +: CB]),
			.t01(t01_s3[c*CB +: CB]), .t11(t11_s3[c*CB +: CB]),
			.w00(w00_s3), .w10(w10_s3), .w01(w01_s3), .w11(w11_s3),
			.res(ch[c])
		);
	end

	assign result_valid = vld_s5;
	assign red_out   = 8'(ch[0]);
	assign green_out = 8'(ch[1]);
	assign blue_out  = 8'(ch[2]);

	a_wr_not_smp: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_s1 && smp_s1)) else $error("write and sample in one stage");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		smp_s1 |=> ##3 result_valid) else $error("sample lost in pipeline");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(smp_s1, 4)) else $error("result without a sample");
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		smp_s1 |-> fu <= FRB'(1 << FB) && fv <= FRB'(1 << FB))
		else $error("fraction above one");
endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb;
	typedef struct {
		logic [7:0] r, g, b;
	} rgb_t;

	class texel_scoreboard;
		logic [23:0] texels [0:65535];
		int unsigned width_reg = 2, height_reg = 2;
		rgb_t pending_rgb[$];
		int errors = 0;

		task report(string what);
			errors++;
			$display("ERROR %0t: %s", $realtime, what);
		endtask

		function void set_reg(bts_pkg::reg_idx_t idx, logic [8:0] val);
			if (idx == bts_pkg::REG_TEX_WIDTH) width_reg = val;
			else height_reg = val;
		endfunction

		function longint eff(int unsigned r);
			if (r == 0) return 1;
			if (r > 256) return 256;
			return r;
		endfunction

		function void split(longint c, longint sz, output longint idx, output longint frac);
			longint prod;
			prod = c * sz;
			idx = prod >> 16;
			if (idx >= sz) idx = sz - 1;
			frac = prod - (idx << 16);
		endfunction

		// texel addresses of the four neighbours: 00, 10, 01, 11
		function void corners(logic [16:0] u, logic [16:0] v, output int a[4],
				output longint fu, output longint fv);
			longint w, h, uu, vv, i, j;
			w = eff(width_reg);
			h = eff(height_reg);
			uu = (u > 65536) ? 65536 : u;
			vv = (v > 65536) ? 65536 : v;
			vv = 65536 - vv;
			split(uu, w, i, fu);
			split(vv, h, j, fv);
			a[0] = int'(j * 256 + i);
			a[1] = int'(j * 256 + (i + 1) % w);
			a[2] = int'(((j + 1) % h) * 256 + i);
			a[3] = int'(((j + 1) % h) * 256 + (i + 1) % w);
		endfunction

		function void note_request(logic op, logic [16:0] u, logic [16:0] v,
				logic [7:0] x, logic [7:0] y, logic [23:0] rgb);
			int a[4];
			longint fu, fv, acc;
			longint wt[4];
			rgb_t res;
			if (op == bts_pkg::OP_WRITE) begin
				texels[{y, x}] = rgb;
				return;
			end
			corners(u, v, a, fu, fv);
			wt[0] = (65536 - fu) * (65536 - fv);
			wt[1] = fu * (65536 - fv);
			wt[2] = (65536 - fu) * fv;
			wt[3] = fu * fv;
			for (int c = 0; c < 3; c++) begin
				acc = 0;
				for (int k = 0; k < 4; k++)
					acc += longint'(texels[a[k]][23 - 8*c -: 8]) * wt[k];
				acc = (acc + (longint'(1) << 31)) >> 32;
				if (acc > 255) acc = 255;
				if (c == 0) res.r = 8'(acc);
				else if (c == 1) res.g = 8'(acc);
				else res.b = 8'(acc);
			end
			pending_rgb = {pending_rgb, res};
		endfunction

		task check_result(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			rgb_t e;
			if (pending_rgb.size() == 0) begin
				report($sformatf("unexpected result %h %h %h", r, g, b));
				return;
			end
			e = pending_rgb.pop_front();
			if (r !== e.r) report($sformatf("red %h, expected %h", r, e.r));
			if (g !== e.g) report($sformatf("green %h, expected %h", g, e.g));
			if (b !== e.b) report($sformatf("blue %h, expected %h", b, e.b));
		endtask
	endclass

	logic clk, arst_n, start, busy, opcode;
	logic [16:0] u_coord, v_coord;
	logic [7:0] texel_x, texel_y, red_in, green_in, blue_in;
	logic cfg_valid, cfg_ready, cfg_index;
	logic [8:0] cfg_data;
	logic result_valid;
	logic [7:0] red_out, green_out, blue_out;

	texel_scoreboard sb = new();
	bit written [0:65535];
	int idle_pct;

	bilinear_texture_sampler_unit dut (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && result_valid) sb.check_result(red_out, green_out, blue_out);

	task send(logic op, logic [16:0] u, logic [16:0] v, logic [7:0] x, logic [7:0] y,
			logic [23:0] rgb);
		opcode <= op;
		u_coord <= u;
		v_coord <= v;
		texel_x <= x;
		texel_y <= y;
		{red_in, green_in, blue_in} <= rgb;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_request(op, u, v, x, y, rgb);
		if (op == bts_pkg::OP_WRITE) written[{y, x}] = 1'b1;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task write_texel(int addr);
		send(bts_pkg::OP_WRITE, 17'($urandom), 17'($urandom), addr[7:0], addr[15:8],
			24'($urandom));
	endtask

	// make sure no unwritten texel is read, then sample
	task sample(logic [16:0] u, logic [16:0] v);
		int a[4];
		longint fu, fv;
		sb.corners(u, v, a, fu, fv);
		for (int k = 0; k < 4; k++)
			if (!written[a[k]]) write_texel(a[k]);
		send(bts_pkg::OP_SAMPLE, u, v, 8'($urandom), 8'($urandom), 24'($urandom));
	endtask

	task write_reg(bts_pkg::reg_idx_t idx, logic [8:0] val);
		start <= 1'b0;
		while (sb.pending_rgb.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	function logic [16:0] rand_coord();
		case ($urandom_range(9))
			0: return 17'd0;
			1: return 17'd65536;
			2: return 17'($urandom_range(65537, 131071));
			default: return 17'($urandom_range(65536));
		endcase
	endfunction

	task random_phase(int n);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(99) < 20)
				write_texel($urandom_range(65535));
			else
				sample(rand_coord(), rand_coord());
		end
	endtask

	initial begin
		int sizes[10][2];
		int modes[4];
		arst_n <= 1'b0;
		start <= 1'b0;
		opcode <= bts_pkg::OP_WRITE;
		u_coord <= '0;
		v_coord <= '0;
		texel_x <= '0;
		texel_y <= '0;
		red_in <= '0;
		green_in <= '0;
		blue_in <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= bts_pkg::REG_TEX_WIDTH;
		cfg_data <= '0;
		idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset size 2x2: channel extremes and coordinate corners
		send(bts_pkg::OP_WRITE, 0, 0, 0, 0, 24'hFF00FF);
		send(bts_pkg::OP_WRITE, 0, 0, 1, 0, 24'h00FF00);
		send(bts_pkg::OP_WRITE, 0, 0, 0, 1, 24'hFFFFFF);
		send(bts_pkg::OP_WRITE, 0, 0, 1, 1, 24'h000000);
		send(bts_pkg::OP_WRITE, 0, 0, 255, 255, 24'h123456);
		sample(0, 0);
		sample(65536, 65536);
		sample(65536, 0);
		sample(0, 65536);
		sample(32768, 32768);
		sample(131071, 131071);
		sample(16384, 49152);
		sample(1, 65535);
		sample(65535, 1);

		sizes = '{'{2, 2}, '{1, 1}, '{256, 256}, '{256, 1}, '{1, 256}, '{0, 511},
			'{3, 5}, '{257, 0}, '{-1, -1}, '{-1, -1}};
		modes = '{0, 60, 0, 25};
		foreach (sizes[p]) begin
			write_reg(bts_pkg::REG_TEX_WIDTH, sizes[p][0] < 0 ? 9'($urandom_range(1, 256))
				: 9'(sizes[p][0]));
			write_reg(bts_pkg::REG_TEX_HEIGHT, sizes[p][1] < 0 ? 9'($urandom_range(1, 256))
				: 9'(sizes[p][1]));
			idle_pct = modes[p % 4];
			sample(65536, 65536);
			sample(0, 0);
			random_phase(48);
		end

		start <= 1'b0;
		while (sb.pending_rgb.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
